// ===== hw/rtl/lfrs_pkg.sv =====
// shared types and constants for the lcd frame store serialiser
// no dependencies; used by lfrs_ctrl, lfrs_datapath and the top level
`default_nettype none

package lfrs_pkg;

  localparam int unsigned StoreBytesDefault = 504;
  localparam int unsigned ByteW = 8;

  typedef enum logic [1:0] {
    CMD_DRAW    = 2'd0,
    CMD_REFRESH = 2'd1,
    CMD_SEND    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ROP_OR       = 3'd0,
    ROP_CLEAR    = 3'd1,
    ROP_OVER     = 3'd2,
    ROP_OVER_INV = 3'd3,
    ROP_XOR      = 3'd4
  } rop_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAW_WR,
    ST_LOAD,
    ST_SHIFT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic clr_wr;
    logic draw_rd;
    logic draw_wr;
    logic refresh_rd;
    logic refresh_load;
    logic cmd_load;
    logic shift;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic draw_ok;
    logic pending;
    logic clr_done;
    logic bit_done;
  } stat_t;

  function automatic logic [ByteW-1:0] reverse_byte(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] r;
    for (int i = 0; i < ByteW; i++) begin
      r[i] = b[ByteW-1-i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lfrs_ctrl.sv =====
// sequencing state machine for the lcd frame store serialiser
// depends on lfrs_pkg; drives lfrs_datapath through ctl_t
`default_nettype none

module lfrs_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [1:0]    command_i,
  input  wire lfrs_pkg::stat_t stat_i,
  output lfrs_pkg::ctl_t     ctl_o,
  output logic               busy_o,
  output logic               strobe_o
);

  lfrs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lfrs_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    ctl_o    = '0;
    busy_o   = 1'b1;
    strobe_o = 1'b0;
    unique case (state_q)
      lfrs_pkg::ST_CLEAR: begin
        ctl_o.clr_wr = 1'b1;
        if (stat_i.clr_done) begin
          state_d = lfrs_pkg::ST_IDLE;
        end
      end
      lfrs_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          unique case (lfrs_pkg::cmd_e'(command_i))
            lfrs_pkg::CMD_DRAW: begin
              if (stat_i.draw_ok) begin
                ctl_o.draw_rd = 1'b1;
                state_d       = lfrs_pkg::ST_DRAW_WR;
              end
            end
            lfrs_pkg::CMD_REFRESH: begin
              if (stat_i.pending) begin
                ctl_o.refresh_rd = 1'b1;
                state_d          = lfrs_pkg::ST_LOAD;
              end
            end
            lfrs_pkg::CMD_SEND: begin
              ctl_o.cmd_load = 1'b1;
              state_d        = lfrs_pkg::ST_SHIFT;
            end
            default: begin
              state_d = lfrs_pkg::ST_IDLE;
            end
          endcase
        end
      end
      lfrs_pkg::ST_DRAW_WR: begin
        ctl_o.draw_wr = 1'b1;
        state_d       = lfrs_pkg::ST_IDLE;
      end
      lfrs_pkg::ST_LOAD: begin
        ctl_o.refresh_load = 1'b1;
        state_d            = lfrs_pkg::ST_SHIFT;
      end
      lfrs_pkg::ST_SHIFT: begin
        ctl_o.shift = 1'b1;
        strobe_o    = 1'b1;
        if (stat_i.bit_done) begin
          state_d = lfrs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lfrs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lfrs_datapath.sv =====
// frame store memory, raster ops, refresh pointer and serial shifter
// depends on lfrs_pkg; controlled by lfrs_ctrl through ctl_t
`default_nettype none

module lfrs_datapath #(
  parameter int unsigned STORE_BYTES = lfrs_pkg::StoreBytesDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire lfrs_pkg::ctl_t ctl_i,
  output lfrs_pkg::stat_t    stat_o,
  input  wire logic [8:0]    pixel_index_i,
  input  wire logic [7:0]    pixel_bits_i,
  input  wire logic [7:0]    bit_mask_i,
  input  wire logic [2:0]    draw_mode_i,
  input  wire logic [7:0]    lcd_command_i,
  output logic               serial_bit_o,
  output logic               data_select_o,
  output logic               last_bit_o,
  output logic               frame_end_o
);

  localparam int unsigned AddrW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(STORE_BYTES - 1);

  logic [7:0] mem_q [STORE_BYTES];

  logic [AddrW-1:0] clr_q;
  logic [AddrW-1:0] ptr_q;
  logic             pending_q;
  logic [AddrW-1:0] idx_q;
  logic [7:0]       bits_q;
  logic [7:0]       mask_q;
  logic [2:0]       mode_q;
  logic [7:0]       rdata_q;
  logic [7:0]       shift_q;
  logic [2:0]       cnt_q;
  logic             dsel_q;
  logic             fend_q;
  logic [7:0]       rop_d;
  logic [AddrW-1:0] wr_addr;
  logic [7:0]       wr_data;
  logic [AddrW-1:0] rd_addr;

  assign stat_o.draw_ok  = (32'(pixel_index_i) < 32'(STORE_BYTES)) &&
                           (draw_mode_i <= lfrs_pkg::ROP_XOR);
  assign stat_o.pending  = pending_q;
  assign stat_o.clr_done = (clr_q == LastAddr);
  assign stat_o.bit_done = (cnt_q == 3'd7);

  // raster operation on the entry read in the previous cycle
  always_comb begin
    case (lfrs_pkg::rop_e'(mode_q))
      lfrs_pkg::ROP_OR:       rop_d = rdata_q | bits_q;
      lfrs_pkg::ROP_CLEAR:    rop_d = rdata_q & ~bits_q;
      lfrs_pkg::ROP_OVER:     rop_d = (rdata_q & ~mask_q) | bits_q;
      lfrs_pkg::ROP_OVER_INV: rop_d = (rdata_q & ~mask_q) | (bits_q ^ mask_q);
      default:                rop_d = rdata_q ^ bits_q;
    endcase
  end

  assign wr_addr = ctl_i.clr_wr ? clr_q : idx_q;
  assign wr_data = ctl_i.clr_wr ? 8'd0 : rop_d;
  assign rd_addr = ctl_i.draw_rd ? pixel_index_i[AddrW-1:0] : ptr_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.clr_wr || ctl_i.draw_wr) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.draw_rd || ctl_i.refresh_rd) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // draw operands
  always_ff @(posedge clk_i) begin
    if (ctl_i.draw_rd) begin
      idx_q  <= pixel_index_i[AddrW-1:0];
      bits_q <= pixel_bits_i;
      mask_q <= bit_mask_i;
      mode_q <= draw_mode_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= '0;
      ptr_q     <= '0;
      pending_q <= 1'b0;
    end else begin
      if (ctl_i.clr_wr) begin
        clr_q <= clr_q + 1'b1;
      end
      if (ctl_i.draw_wr) begin
        pending_q <= 1'b1;
      end
      if (ctl_i.refresh_load) begin
        if (ptr_q == LastAddr) begin
          ptr_q     <= '0;
          pending_q <= 1'b0;
        end else begin
          ptr_q <= ptr_q + 1'b1;
        end
      end
    end
  end

  // shifter always moves right; command bytes are reversed on load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctl_i.refresh_load || ctl_i.cmd_load) begin
      cnt_q <= '0;
    end else if (ctl_i.shift) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.refresh_load) begin
      shift_q <= rdata_q;
      dsel_q  <= 1'b1;
      fend_q  <= (ptr_q == LastAddr);
    end else if (ctl_i.cmd_load) begin
      shift_q <= lfrs_pkg::reverse_byte(lcd_command_i);
      dsel_q  <= 1'b0;
      fend_q  <= 1'b0;
    end else if (ctl_i.shift) begin
      shift_q <= {1'b0, shift_q[7:1]};
    end
  end

  assign serial_bit_o  = shift_q[0];
  assign data_select_o = dsel_q;
  assign last_bit_o    = (cnt_q == 3'd7);
  assign frame_end_o   = fend_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lcd_framebuffer_rop_serializer.sv =====
// draw: read, then write back; refresh step: read, load, 8 bits; command: load, 8 bits
// transactions: one at a time, the next is taken the cycle after the last ends
// bits leave one per cycle in the shift state, after the byte is loaded
// an ignored transaction does not leave the idle state
// reset: asynchronous active low; then a clearing pass zeroes every byte of the
// frame store with busy_o high; results cannot be stalled by the receiver
`default_nettype none

module lcd_framebuffer_rop_serializer #(
  parameter int unsigned STORE_BYTES = lfrs_pkg::StoreBytesDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // transaction request
  input  wire logic       start_i,
  output logic            busy_o,
  input  wire logic [1:0] command_i,
  input  wire logic [8:0] pixel_index_i,
  input  wire logic [7:0] pixel_bits_i,
  input  wire logic [7:0] bit_mask_i,
  input  wire logic [2:0] draw_mode_i,
  input  wire logic [7:0] lcd_command_i,
  // serial results, one per strobe
  output logic            strobe_o,
  output logic            serial_bit_o,
  output logic            data_select_o,
  output logic            last_bit_o,
  output logic            frame_end_o
);

  // command and status between the state machine and the datapath
  lfrs_pkg::ctl_t  ctl;
  lfrs_pkg::stat_t stat;

  // sequencer: clearing pass, draw read-modify-write, byte load and bit shifting
  lfrs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .command_i (command_i),
    .stat_i    (stat),
    .ctl_o     (ctl),
    .busy_o    (busy_o),
    .strobe_o  (strobe_o)
  );

  // frame store, raster operations, refresh pointer and output shifter
  lfrs_datapath #(
    .STORE_BYTES (STORE_BYTES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .stat_o        (stat),
    .pixel_index_i (pixel_index_i),
    .pixel_bits_i  (pixel_bits_i),
    .bit_mask_i    (bit_mask_i),
    .draw_mode_i   (draw_mode_i),
    .lcd_command_i (lcd_command_i),
    .serial_bit_o  (serial_bit_o),
    .data_select_o (data_select_o),
    .last_bit_o    (last_bit_o),
    .frame_end_o   (frame_end_o)
  );

`ifndef NO_ASSERTIONS
  // a bit is only ever sent while a transaction is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni) strobe_o |-> busy_o)
    else $error("strobe without busy");

  // a byte's bits come out without gaps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !last_bit_o) |=> strobe_o)
    else $error("gap inside a serial byte");

  // the eighth bit ends the transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && last_bit_o) |=> !strobe_o && !busy_o)
    else $error("no return to idle after last bit");

  // frame end only marks display data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && frame_end_o) |-> data_select_o)
    else $error("frame end on a command byte");
`endif

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// self-checking bench for lcd_framebuffer_rop_serializer: draw, refresh and command traffic
// depends on lfrs_pkg and the top level rtl; holds its own frame shadow as scoreboard

import lfrs_pkg::*;

// one serial bit as seen on the result ports
typedef struct packed {
  logic serial_bit;
  logic data_select;
  logic last_bit;
  logic frame_end;
} lcd_bit_t;

// shadow of the frame store plus the queue of serial bits still owed by the block
class frame_shadow;
  bit [7:0]    frame_bytes [StoreBytesDefault];
  int unsigned scan_ptr;
  bit          refresh_due;
  int unsigned mismatches;
  lcd_bit_t    expected_bits [$];

  function new();
    foreach (frame_bytes[i]) frame_bytes[i] = '0;
    scan_ptr    = 0;
    refresh_due = 1'b0;
    mismatches  = 0;
  endfunction

  // raster operation on one byte column
  function bit [7:0] combine_pixels(bit [7:0] w, bit [7:0] d, bit [7:0] m, bit [2:0] mode);
    case (mode)
      ROP_OR:       return w | d;
      ROP_CLEAR:    return w & ~d;
      ROP_OVER:     return (w & ~m) | d;
      ROP_OVER_INV: return (w & ~m) | (d ^ m);
      default:      return w ^ d;
    endcase
  endfunction

  // note an accepted transaction; returns 1 when it had any effect
  function bit apply_transaction(bit [1:0] cmd, bit [8:0] idx, bit [7:0] pix, bit [7:0] mask,
                                 bit [2:0] mode, bit [7:0] lcd);
    bit [7:0] column;
    bit       at_end;
    case (cmd)
      CMD_DRAW: begin
        if (idx >= StoreBytesDefault || mode > ROP_XOR) return 1'b0;
        frame_bytes[idx] = combine_pixels(frame_bytes[idx], pix, mask, mode);
        refresh_due = 1'b1;
        return 1'b1;
      end
      CMD_REFRESH: begin
        if (!refresh_due) return 1'b0;
        column = frame_bytes[scan_ptr];
        at_end = (scan_ptr == StoreBytesDefault - 1);
        for (int k = 0; k < 8; k++) begin
          expected_bits.push_back(lcd_bit_t'{column[k], 1'b1, k == 7, at_end});
        end
        if (at_end) begin
          scan_ptr    = 0;
          refresh_due = 1'b0;
        end else begin
          scan_ptr++;
        end
        return 1'b1;
      end
      CMD_SEND: begin
        for (int k = 0; k < 8; k++) begin
          expected_bits.push_back(lcd_bit_t'{lcd[7-k], 1'b0, k == 7, 1'b0});
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function void compare_field(string name, logic want, logic got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0b actual %0b", $time, name, want, got);
    end
  endfunction

  function void check_bit(lcd_bit_t got);
    lcd_bit_t want;
    if (expected_bits.size() == 0) begin
      mismatches++;
      $display("%0t: serial bit with none expected, actual bit %0b dsel %0b last %0b end %0b",
               $time, got.serial_bit, got.data_select, got.last_bit, got.frame_end);
      return;
    end
    want = expected_bits.pop_front();
    compare_field("serial_bit", want.serial_bit, got.serial_bit);
    compare_field("data_select", want.data_select, got.data_select);
    compare_field("last_bit", want.last_bit, got.last_bit);
    compare_field("frame_end", want.frame_end, got.frame_end);
  endfunction
endclass

module testbench;

  localparam int unsigned StoreBytes    = StoreBytesDefault;
  localparam int unsigned IndexLast     = 511;
  // draw modes with no raster operation behind them
  localparam logic [2:0]  RopUndefFirst = 3'd5;
  localparam logic [2:0]  RopUndefLast  = 3'd7;
  localparam int unsigned RandomItems   = 360;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       start_i       = 1'b0;
  logic [1:0] command_i     = CMD_NONE;
  logic [8:0] pixel_index_i = '0;
  logic [7:0] pixel_bits_i  = '0;
  logic [7:0] bit_mask_i    = '0;
  logic [2:0] draw_mode_i   = ROP_OR;
  logic [7:0] lcd_command_i = '0;
  logic       busy_o;
  logic       strobe_o;
  logic       serial_bit_o;
  logic       data_select_o;
  logic       last_bit_o;
  logic       frame_end_o;

  frame_shadow sb;
  int unsigned sent_items;
  int unsigned burst_left;
  bit          req_high;

  lcd_framebuffer_rop_serializer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .command_i     (command_i),
    .pixel_index_i (pixel_index_i),
    .pixel_bits_i  (pixel_bits_i),
    .bit_mask_i    (bit_mask_i),
    .draw_mode_i   (draw_mode_i),
    .lcd_command_i (lcd_command_i),
    .strobe_o      (strobe_o),
    .serial_bit_o  (serial_bit_o),
    .data_select_o (data_select_o),
    .last_bit_o    (last_bit_o),
    .frame_end_o   (frame_end_o)
  );

  always #6 clk_i = ~clk_i;

  // result side: every strobe is a serial bit that must match the oldest owed bit
  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) begin
      sb.check_bit(lcd_bit_t'{serial_bit_o, data_select_o, last_bit_o, frame_end_o});
    end
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // sender bursts: start stays high inside a burst, random idle gaps between bursts
  task automatic pace();
    int unsigned gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 5);
      start_i  <= 1'b0;
      req_high = 1'b0;
      repeat (gap) @(posedge clk_i);
      // occasionally a long stretch with no idling at all
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
    end
  endtask

  // present one transaction and hold it until the block takes it
  task automatic issue(cmd_e cmd, logic [8:0] idx, logic [7:0] pix, logic [7:0] mask,
                       logic [2:0] mode, logic [7:0] lcd);
    start_i       <= 1'b1;
    req_high      = 1'b1;
    command_i     <= cmd;
    pixel_index_i <= idx;
    pixel_bits_i  <= pix;
    bit_mask_i    <= mask;
    draw_mode_i   <= mode;
    lcd_command_i <= lcd;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    void'(sb.apply_transaction(cmd, idx, pix, mask, mode, lcd));
    sent_items++;
    pace();
  endtask

  // unused fields carry junk on refresh and command transactions
  task automatic refresh_step();
    issue(CMD_REFRESH, 9'($urandom), 8'($urandom), 8'($urandom), 3'($urandom), 8'($urandom));
  endtask

  task automatic send_byte(logic [7:0] lcd);
    issue(CMD_SEND, 9'($urandom), 8'($urandom), 8'($urandom), 3'($urandom), lcd);
  endtask

  // draw into [lo, hi], now and then beyond the store or with an undefined mode
  task automatic random_draw(int unsigned lo, int unsigned hi);
    logic [8:0] idx;
    logic [2:0] mode;
    idx = ($urandom_range(0, 11) == 0) ? 9'($urandom_range(StoreBytes, IndexLast))
                                       : 9'($urandom_range(lo, hi));
    mode = ($urandom_range(0, 11) == 0) ? 3'($urandom_range(RopUndefFirst, RopUndefLast))
                                        : 3'($urandom_range(ROP_OR, ROP_XOR));
    issue(CMD_DRAW, idx, 8'($urandom), 8'($urandom), mode, 8'($urandom));
  endtask

  initial begin : stimulus
    int unsigned flavour;
    int unsigned ahead;
    int unsigned drain;

    sb         = new();
    sent_items = 0;
    burst_left = 1;
    req_high   = 1'b0;

    // single reset; the block then runs its clearing pass with busy high
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: refresh with nothing pending must stay silent
    refresh_step();
    // command bytes at the extremes and a mixed pattern
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);
    // every raster operation, including mask bits outside the pixels and an empty mask
    issue(CMD_DRAW, 9'd0, 8'hFF, 8'h00, ROP_OR, 8'h00);
    issue(CMD_DRAW, 9'd0, 8'h5A, 8'hFF, ROP_CLEAR, 8'h00);
    issue(CMD_DRAW, 9'd1, 8'h81, 8'h3C, ROP_OVER, 8'h00);
    issue(CMD_DRAW, 9'd2, 8'h0F, 8'hFF, ROP_OVER_INV, 8'h00);
    issue(CMD_DRAW, 9'd3, 8'h00, 8'h00, ROP_OVER, 8'h00);
    issue(CMD_DRAW, 9'(StoreBytes - 1), 8'hFF, 8'h00, ROP_XOR, 8'h00);
    issue(CMD_DRAW, 9'(StoreBytes - 1), 8'h0F, 8'h00, ROP_XOR, 8'h00);
    issue(CMD_DRAW, 9'd300, 8'hC3, 8'h00, ROP_OR, 8'h00);
    // draws beyond the store and with undefined modes are dropped
    issue(CMD_DRAW, 9'(StoreBytes), 8'hFF, 8'hFF, ROP_OR, 8'h00);
    issue(CMD_DRAW, 9'(IndexLast), 8'hFF, 8'hFF, ROP_XOR, 8'h00);
    issue(CMD_DRAW, 9'd4, 8'hFF, 8'hFF, RopUndefFirst, 8'h00);
    issue(CMD_DRAW, 9'd4, 8'hFF, 8'hFF, RopUndefLast, 8'h00);
    // undefined command does nothing
    issue(CMD_NONE, 9'd0, 8'hFF, 8'hFF, ROP_OR, 8'hFF);
    // first columns of a refresh, then a draw to a column not yet sent
    refresh_step();
    refresh_step();
    refresh_step();
    issue(CMD_DRAW, 9'd3, 8'h96, 8'h00, ROP_XOR, 8'h00);
    refresh_step();

    // random mix of short sequences
    while (sent_items < RandomItems) begin
      flavour = $urandom_range(0, 9);
      case (flavour)
        0, 1, 2, 3: begin
          repeat ($urandom_range(1, 6)) random_draw(0, StoreBytes - 1);
        end
        4, 5, 6: begin
          repeat ($urandom_range(1, 12)) refresh_step();
        end
        7: begin
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
        end
        8: begin
          // noise: undefined commands and draws that must be dropped
          issue(CMD_NONE, 9'($urandom), 8'($urandom), 8'($urandom), 3'($urandom), 8'($urandom));
          issue(CMD_DRAW, 9'($urandom_range(StoreBytes, IndexLast)), 8'($urandom),
                8'($urandom), 3'($urandom_range(ROP_OR, ROP_XOR)), 8'($urandom));
          issue(CMD_DRAW, 9'($urandom_range(0, StoreBytes - 1)), 8'($urandom), 8'($urandom),
                3'($urandom_range(RopUndefFirst, RopUndefLast)), 8'($urandom));
        end
        default: begin
          // draws just ahead of the refresh position interleaved with refresh steps
          repeat ($urandom_range(2, 8)) begin
            ahead = sb.scan_ptr + 8;
            if (ahead > StoreBytes - 1) ahead = StoreBytes - 1;
            random_draw(sb.scan_ptr, ahead);
            refresh_step();
          end
        end
      endcase
    end

    if (req_high) start_i <= 1'b0;

    // let the last transaction drain, then a little extra for stray strobes
    drain = 0;
    while (sb.expected_bits.size() != 0 && drain < 200) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (12) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.expected_bits.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== lcd_framebuffer_rop_serializer.f =====
hw/rtl/lfrs_pkg.sv
hw/rtl/lfrs_ctrl.sv
hw/rtl/lfrs_datapath.sv
hw/rtl/lcd_framebuffer_rop_serializer.sv
bench/testbench.sv
